/* hdl/i2cdw_pkg.sv */
// i2cdw_pkg: types and constants shared by the display write framer
// no dependencies
`timescale 1ns / 1ps

package i2cdw_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned FrameW = 3 * ByteW;
  localparam int unsigned CfgIdxW = 2;

  // bit counter runs over eight data bits then the acknowledge clock
  localparam logic [3:0] LastBit  = 4'd8;
  localparam logic [1:0] LastByte = 2'd2;

  localparam logic [ByteW-1:0] DevAddrRst = 8'h78;
  localparam logic [ByteW-1:0] CmdCtrlRst = 8'h00;
  localparam logic [ByteW-1:0] DatCtrlRst = 8'h40;

  typedef enum logic [1:0] {
    SLOT_START = 2'd0,
    SLOT_BIT   = 2'd1,
    SLOT_ACK   = 2'd2,
    SLOT_STOP  = 2'd3
  } slot_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEVICE_ADDRESS  = 2'd0,
    CFG_COMMAND_CONTROL = 2'd1,
    CFG_DATA_CONTROL    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_BITS  = 4'b0100,
    ST_STOP  = 4'b1000
  } gen_state_e;

  // assembled transaction waiting for the slot generator
  typedef struct packed {
    logic              valid;
    logic [FrameW-1:0] bits;
  } frame_t;

endpackage

/* hdl/i2cdw_if.sv */
// i2cdw_req_if and i2cdw_slot_if: valid/ready channels of the framer
// no dependencies
`timescale 1ns / 1ps

interface i2cdw_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] payload_byte;

  modport source (output valid, req_type, payload_byte, input ready);
  modport sink   (input valid, req_type, payload_byte, output ready);
endinterface

interface i2cdw_slot_if;
  logic       valid;
  logic       ready;
  logic [1:0] slot_kind;
  logic       sda_level;
  logic       last_slot;

  modport source (output valid, slot_kind, sda_level, last_slot, input ready);
  modport sink   (input valid, slot_kind, sda_level, last_slot, output ready);
endinterface

/* hdl/i2cdw_req_stage.sv */
// i2cdw_req_stage: configuration registers and request input register
// depends on i2cdw_pkg and i2cdw_if
`timescale 1ns / 1ps

module i2cdw_req_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [i2cdw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [i2cdw_pkg::ByteW-1:0]   cfg_wdata_i,
  i2cdw_req_if.sink                     req_i,
  input  logic                          take_i,
  output i2cdw_pkg::frame_t             frame_o
);
  import i2cdw_pkg::*;

  logic [ByteW-1:0]  dev_addr_q, cmd_ctrl_q, dat_ctrl_q;
  logic              full_q, full_d;
  logic [FrameW-1:0] bits_q;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DevAddrRst;
      cmd_ctrl_q <= CmdCtrlRst;
      dat_ctrl_q <= DatCtrlRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEVICE_ADDRESS:  dev_addr_q <= cfg_wdata_i;
        CFG_COMMAND_CONTROL: cmd_ctrl_q <= cfg_wdata_i;
        CFG_DATA_CONTROL:    dat_ctrl_q <= cfg_wdata_i;
        default: ; // unused index, write dropped
      endcase
    end
  end

  // free slot, or the held frame leaves in this cycle
  assign req_i.ready = !full_q || take_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    full_d = full_q;
    if (take_i) full_d = 1'b0;
    if (accept) full_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bits_q <= {dev_addr_q, (req_i.req_type ? dat_ctrl_q : cmd_ctrl_q), req_i.payload_byte};
    end
  end

  assign frame_o.valid = full_q;
  assign frame_o.bits  = bits_q;

endmodule

/* hdl/i2cdw_slot_gen.sv */
// i2cdw_slot_gen: walks one frame through start, bits, ack clocks and stop
// depends on i2cdw_pkg and i2cdw_if
`timescale 1ns / 1ps

module i2cdw_slot_gen (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  i2cdw_pkg::frame_t frame_i,
  output logic              take_o,
  i2cdw_slot_if.source      slot_o
);
  import i2cdw_pkg::*;

  gen_state_e        state_q, state_d;
  logic [FrameW-1:0] sh_q, sh_d;
  logic [3:0]        bit_q, bit_d;
  logic [1:0]        byte_q, byte_d;
  logic              out_valid_q, out_valid_d;
  slot_kind_e        kind_q, kind_d;
  logic              sda_q, sda_d, last_q, last_d;
  logic              out_free;

  assign out_free = !out_valid_q || slot_o.ready;

  always_comb begin
    state_d     = state_q;
    sh_d        = sh_q;
    bit_d       = bit_q;
    byte_d      = byte_q;
    out_valid_d = out_valid_q && !slot_o.ready;
    kind_d      = kind_q;
    sda_d       = sda_q;
    last_d      = last_q;
    take_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (frame_i.valid) begin
          take_o  = 1'b1;
          sh_d    = frame_i.bits;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = SLOT_START;
          sda_d       = 1'b0;
          last_d      = 1'b0;
          bit_d       = '0;
          byte_d      = '0;
          state_d     = ST_BITS;
        end
      end
      ST_BITS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = 1'b0;
          if (bit_q == LastBit) begin
            kind_d = SLOT_ACK;
            sda_d  = 1'b0;
            bit_d  = '0;
            if (byte_q == LastByte) begin
              state_d = ST_STOP;
            end else begin
              byte_d = byte_q + 2'd1;
            end
          end else begin
            kind_d = SLOT_BIT;
            sda_d  = sh_q[FrameW-1];
            sh_d   = {sh_q[FrameW-2:0], 1'b0};
            bit_d  = bit_q + 4'd1;
          end
        end
      end
      ST_STOP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = SLOT_STOP;
          sda_d       = 1'b0;
          last_d      = 1'b1;
          // chain straight into the next transaction when one waits
          if (frame_i.valid) begin
            take_o  = 1'b1;
            sh_d    = frame_i.bits;
            state_d = ST_START;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
      byte_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
      byte_q      <= byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    kind_q <= kind_d;
    sda_q  <= sda_d;
    last_q <= last_d;
  end

  assign slot_o.valid     = out_valid_q;
  assign slot_o.slot_kind = kind_q;
  assign slot_o.sda_level = sda_q;
  assign slot_o.last_slot = last_q;

endmodule

/* hdl/i2c_display_write_framer.sv */
// i2c_display_write_framer: top level of the display write framer
// depends on i2cdw_pkg, i2cdw_if, i2cdw_req_stage and i2cdw_slot_gen
`timescale 1ns / 1ps

// usage
//   req_i takes one write request item: req_type (0 command, 1 display data)
//   and payload_byte. slot_o gives 29 bus slot items per request: a start,
//   address byte, control byte and payload byte msb first, each byte closed
//   by an acknowledge clock that is never checked, then a stop with last_slot
//   set. registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i:
//   0 device address, 1 command control byte, 2 data control byte
//   a taken request passes the input register, the start state and the
//   output register before its start slot is valid. throughput: one slot
//   per cycle when slot_o never stalls, set by the slot generator's single
//   output register. one request waits in the input register while the
//   previous one is being sent, so req_i takes one item while slot_o is busy
//   a stall on slot_o holds the current slot and freezes the generator;
//   req_i then stays ready only until its input register is full
//   reset: registers return to 0x78 / 0x00 / 0x40, both channels empty
module i2c_display_write_framer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [i2cdw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [i2cdw_pkg::ByteW-1:0]   cfg_wdata_i,
  i2cdw_req_if.sink                     req_i,
  i2cdw_slot_if.source                  slot_o
);
  import i2cdw_pkg::*;

  // frame handed from the input register to the slot generator
  frame_t frame;
  logic   take;

  i2cdw_req_stage u_req_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .take_i      (take),
    .frame_o     (frame)
  );

  i2cdw_slot_gen u_slot_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame),
    .take_o  (take),
    .slot_o  (slot_o)
  );

`ifndef SYNTHESIS
  // the last flag marks the stop slot and nothing else
  a_last_is_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_o.valid |-> (slot_o.last_slot == (slot_o.slot_kind == SLOT_STOP)))
    else $error("last_slot out of step with stop slot");

  // the data line is driven high only in data bit slots
  a_sda_bits_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_o.valid && slot_o.sda_level) |-> (slot_o.slot_kind == SLOT_BIT))
    else $error("sda high outside a data bit slot");

  // a taken request is held until the generator picks it up
  a_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> frame.valid)
    else $error("taken request lost");

  // the generator only picks up a frame that is present
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> frame.valid)
    else $error("frame taken while none waits");
`endif

endmodule
